// ===== design/udef_pkg.sv =====
// Shared types and constants for the USB descriptor endpoint finder.
// No dependencies.
package udef_pkg;

    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] MIN_TOTAL      = 8'd9;
    localparam logic [7:0] MIN_IFACE_LEN  = 8'd9;
    localparam logic [7:0] MIN_EP_LEN     = 8'd7;
    localparam logic [1:0] XFER_INTERRUPT = 2'd3;

    localparam logic [7:0] IFACE_NUMBER_RST   = 8'h00;
    localparam logic [7:0] ALT_SETTING_RST    = 8'h00;
    localparam logic [7:0] IFACE_CLASS_RST    = 8'hFF;
    localparam logic [7:0] IFACE_SUBCLASS_RST = 8'h47;
    localparam logic [7:0] IFACE_PROTOCOL_RST = 8'hD0;

    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IFACE_NUMBER   = 3'd0,
        CFG_ALT_SETTING    = 3'd1,
        CFG_IFACE_CLASS    = 3'd2,
        CFG_IFACE_SUBCLASS = 3'd3,
        CFG_IFACE_PROTOCOL = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_MALFORMED = 2'd2
    } walk_status_t;

    typedef struct packed {
        logic         found;
        logic [7:0]   in_endpoint;
        logic [7:0]   out_endpoint;
        walk_status_t walk_status;
    } result_t;

endpackage

// ===== design/udef_desc_if.sv =====
// Descriptor byte channel: valid/ready with one byte and a start marker.
// No dependencies.
interface udef_desc_if;
    logic       valid;
    logic       ready;
    logic [7:0] desc_byte;
    logic       first_byte;

    modport source (output valid, output desc_byte, output first_byte, input ready);
    modport sink   (input valid, input desc_byte, input first_byte, output ready);
endinterface

// ===== design/udef_result_if.sv =====
// Result channel: valid/ready with found flag, endpoint addresses and status.
// No dependencies.
interface udef_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] in_endpoint;
    logic [7:0] out_endpoint;
    logic [1:0] walk_status;

    modport source (output valid, output found, output in_endpoint, output out_endpoint,
                    output walk_status, input ready);
    modport sink   (input valid, input found, input in_endpoint, input out_endpoint,
                    input walk_status, output ready);
endinterface

// ===== design/udef_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// No dependencies.
interface udef_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/usb_descriptor_endpoint_finder.sv =====
// Walks a USB configuration descriptor set and reports interrupt endpoints.
// Depends on udef_pkg, udef_desc_if, udef_result_if, udef_cfg_if.
// A result is registered from the byte that ends the walk, via the skid stage if the result register is held.
// Throughput: one byte per cycle while the skid stage is empty; the walk state updates in a single pass.
// A result register plus a one-entry skid stage keeps input flowing while a
// result waits. Reset (rst_n low, asynchronous) clears the walk to idle and
// loads the default match registers; bytes are ignored until a first byte.
module usb_descriptor_endpoint_finder
(
    input  logic          clk,
    input  logic          rst_n,
    udef_desc_if.sink     desc,
    udef_result_if.source result,
    udef_cfg_if.sink      cfg
);

    logic [7:0] iface_number_reg;
    logic [7:0] alt_setting_reg;
    logic [7:0] iface_class_reg;
    logic [7:0] iface_subclass_reg;
    logic [7:0] iface_protocol_reg;

    logic [15:0] total_reg,  total_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  pos_reg,    pos_next;
    logic [7:0]  dlen_reg,   dlen_next;
    logic [7:0]  dtype_reg,  dtype_next;
    logic        target_reg, target_next;
    logic        match_reg,  match_next;
    logic [7:0]  cap_reg,    cap_next;
    logic [7:0]  in_reg,     in_next;
    logic [7:0]  out_reg,    out_next;
    logic        finished_reg, finished_next;

    logic             out_valid_reg, out_valid_next;
    udef_pkg::result_t out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    udef_pkg::result_t skid_data_reg, skid_data_next;

    logic        accept;
    logic        active;
    logic        res_fire;
    udef_pkg::result_t res;

    logic [15:0] o, t_cur, t_eff;
    logic [7:0]  p, len, dtype, b;
    logic        tgt, mt;
    logic [7:0]  cap, ina, outa;
    logic        err_short, err_first, err_desc, end_desc, end_walk;

    assign cfg.ready  = 1'b1;
    assign desc.ready = !skid_valid_reg;
    assign accept     = desc.valid && desc.ready;
    assign b          = desc.desc_byte;
    assign active     = accept && (desc.first_byte || !finished_reg);

    always_comb
    begin
        if (desc.first_byte)
        begin
            o     = '0;
            p     = '0;
            t_cur = '0;
            dlen_next = '0;
            dtype = '0;
            tgt   = 1'b0;
            mt    = 1'b0;
            cap   = '0;
            ina   = '0;
            outa  = '0;
        end
        else
        begin
            o     = offset_reg;
            p     = pos_reg;
            t_cur = total_reg;
            dlen_next = dlen_reg;
            dtype = dtype_reg;
            tgt   = target_reg;
            mt    = match_reg;
            cap   = cap_reg;
            ina   = in_reg;
            outa  = out_reg;
        end

        t_eff = t_cur;
        if (o == 16'd2)
            t_eff = {t_cur[15:8], b};
        if (o == 16'd3)
            t_eff = {b, t_cur[7:0]};

        if (p == 8'd0)
            dlen_next = b;
        len = dlen_next;
        if (p == 8'd1)
            dtype = b;

        err_short = (o == 16'd3) && (t_eff < {8'd0, udef_pkg::MIN_TOTAL});
        err_first = (o == 16'd3) && (p == 8'd3)
                    && ((len < 8'd2) || ({8'd0, len} > t_eff));
        err_desc  = (p == 8'd1) && (o != 16'd1)
                    && ((len < 8'd2)
                        || (({1'b0, o} + {9'd0, len}) > ({1'b0, t_eff} + 17'd1)));

        match_next  = mt;
        target_next = tgt;
        cap_next    = cap;
        in_next     = ina;
        out_next    = outa;
        if (dtype == udef_pkg::TYPE_INTERFACE && len >= udef_pkg::MIN_IFACE_LEN)
        begin
            case (p)
                8'd2: match_next = (b == iface_number_reg);
                8'd3: match_next = mt && (b == alt_setting_reg);
                8'd5: match_next = mt && (b == iface_class_reg);
                8'd6: match_next = mt && (b == iface_subclass_reg);
                8'd7:
                begin
                    match_next  = mt && (b == iface_protocol_reg);
                    target_next = match_next;
                end
                default: match_next = mt;
            endcase
        end
        else if (tgt && dtype == udef_pkg::TYPE_ENDPOINT && len >= udef_pkg::MIN_EP_LEN)
        begin
            if (p == 8'd2)
                cap_next = b;
            else if (p == 8'd3 && b[1:0] == udef_pkg::XFER_INTERRUPT)
            begin
                if (cap[7])
                    in_next = cap;
                else
                    out_next = cap;
            end
        end

        end_desc = (len >= 8'd2) && (({1'b0, p} + 9'd1) == {1'b0, len});
        end_walk = end_desc && (o >= 16'd3)
                   && (({1'b0, o} + 17'd3) > {1'b0, t_eff});

        offset_next = o + 16'd1;
        pos_next    = end_desc ? 8'd0 : (p + 8'd1);
        total_next  = t_eff;
        dtype_next  = dtype;

        res_fire      = active && (err_short || err_first || err_desc || end_walk);
        finished_next = res_fire ? 1'b1 : (desc.first_byte ? 1'b0 : finished_reg);

        res.in_endpoint  = in_next;
        res.out_endpoint = out_next;
        res.found        = (in_next != 8'd0) && (out_next != 8'd0);
        if (err_short)
            res.walk_status = udef_pkg::STATUS_SHORT;
        else if (err_first || err_desc)
            res.walk_status = udef_pkg::STATUS_MALFORMED;
        else
            res.walk_status = udef_pkg::STATUS_OK;
    end

    // result register with one-entry skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_fire;
                out_data_next  = res;
            end
        end
        else if (res_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = out_data_reg.found;
    assign result.in_endpoint  = out_data_reg.in_endpoint;
    assign result.out_endpoint = out_data_reg.out_endpoint;
    assign result.walk_status  = out_data_reg.walk_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iface_number_reg   <= udef_pkg::IFACE_NUMBER_RST;
            alt_setting_reg    <= udef_pkg::ALT_SETTING_RST;
            iface_class_reg    <= udef_pkg::IFACE_CLASS_RST;
            iface_subclass_reg <= udef_pkg::IFACE_SUBCLASS_RST;
            iface_protocol_reg <= udef_pkg::IFACE_PROTOCOL_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                udef_pkg::CFG_IFACE_NUMBER:   iface_number_reg   <= cfg.data;
                udef_pkg::CFG_ALT_SETTING:    alt_setting_reg    <= cfg.data;
                udef_pkg::CFG_IFACE_CLASS:    iface_class_reg    <= cfg.data;
                udef_pkg::CFG_IFACE_SUBCLASS: iface_subclass_reg <= cfg.data;
                udef_pkg::CFG_IFACE_PROTOCOL: iface_protocol_reg <= cfg.data;
                default:                      iface_number_reg   <= iface_number_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            offset_reg   <= '0;
            pos_reg      <= '0;
            dlen_reg     <= '0;
            dtype_reg    <= '0;
            target_reg   <= 1'b0;
            match_reg    <= 1'b0;
            cap_reg      <= '0;
            in_reg       <= '0;
            out_reg      <= '0;
            finished_reg <= 1'b1;
        end
        else if (active)
        begin
            total_reg    <= total_next;
            offset_reg   <= offset_next;
            pos_reg      <= pos_next;
            dlen_reg     <= dlen_next;
            dtype_reg    <= dtype_next;
            target_reg   <= target_next;
            match_reg    <= match_next;
            cap_reg      <= cap_next;
            in_reg       <= in_next;
            out_reg      <= out_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");

    a_walk_stops: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> finished_reg)
        else $error("walk still running after its result");

    a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.found |-> (result.in_endpoint != 8'd0)
                                         && (result.out_endpoint != 8'd0))
        else $error("found set without both endpoints");

    a_short_no_endpoints: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.walk_status == udef_pkg::STATUS_SHORT)
            |-> (result.in_endpoint == 8'd0) && (result.out_endpoint == 8'd0))
        else $error("short total reported with endpoints");

endmodule

// ===== tb/tb_usb_descriptor_endpoint_finder.sv =====
// Self-checking testbench for usb_descriptor_endpoint_finder: feeds descriptor sets,
// predicts each walk report in a small class and checks it on the result channel.
// Depends on udef_pkg, the three channel interfaces and the block itself.
`timescale 1ns / 100ps

module tb_usb_descriptor_endpoint_finder;

    localparam logic [7:0]  TYPE_CONFIG   = 8'd2;
    localparam logic [7:0]  TYPE_HID      = 8'h21;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned N_PHASES      = 8;
    localparam int unsigned BYTES_PER_PHASE = 250;

    // Walk predictor and store of expected reports
    class walk_predictor;
        logic [7:0]  match_reg [0:4];
        logic [15:0] total_len;
        logic [15:0] offset;
        logic [7:0]  pos;
        logic [7:0]  desc_len;
        logic [7:0]  desc_type;
        logic [7:0]  addr_hold;
        logic [7:0]  in_addr;
        logic [7:0]  out_addr;
        bit          in_target;
        bit          match_ok;
        bit          idle;
        udef_pkg::result_t expected_reports [$];
        int unsigned n_closed;
        int unsigned n_checked;
        int unsigned n_errors;

        function new();
            match_reg[udef_pkg::CFG_IFACE_NUMBER]   = udef_pkg::IFACE_NUMBER_RST;
            match_reg[udef_pkg::CFG_ALT_SETTING]    = udef_pkg::ALT_SETTING_RST;
            match_reg[udef_pkg::CFG_IFACE_CLASS]    = udef_pkg::IFACE_CLASS_RST;
            match_reg[udef_pkg::CFG_IFACE_SUBCLASS] = udef_pkg::IFACE_SUBCLASS_RST;
            match_reg[udef_pkg::CFG_IFACE_PROTOCOL] = udef_pkg::IFACE_PROTOCOL_RST;
            clear_walk();
            idle      = 1'b1;
            n_closed  = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void clear_walk();
            total_len = '0;
            offset    = '0;
            pos       = '0;
            desc_len  = '0;
            desc_type = '0;
            addr_hold = '0;
            in_addr   = '0;
            out_addr  = '0;
            in_target = 1'b0;
            match_ok  = 1'b0;
        endfunction

        function void write_reg(udef_pkg::cfg_index_t idx, logic [7:0] v);
            if (idx <= udef_pkg::CFG_IFACE_PROTOCOL)
                match_reg[idx] = v;
        endfunction

        function void close_walk(udef_pkg::walk_status_t st);
            udef_pkg::result_t r;
            r.found        = (in_addr != 8'd0) && (out_addr != 8'd0);
            r.in_endpoint  = in_addr;
            r.out_endpoint = out_addr;
            r.walk_status  = st;
            expected_reports.push_back(r);
            idle = 1'b1;
            n_closed++;
        endfunction

        function void take_byte(logic [7:0] b, logic first);
            int unsigned o, p, len, n;
            if (first) begin
                clear_walk();
                idle = 1'b0;
            end
            else if (idle)
                return;
            o = offset;
            p = pos;
            if (o == 2)
                total_len[7:0] = b;
            if (o == 3)
                total_len[15:8] = b;
            if (p == 0)
                desc_len = b;
            else if (p == 1)
                desc_type = b;
            len = desc_len;

            if (o == 3) begin
                if (total_len < udef_pkg::MIN_TOTAL) begin
                    close_walk(udef_pkg::STATUS_SHORT);
                    return;
                end
                // first descriptor can only be checked once the total is known
                if (p == o && (len < 2 || len > total_len)) begin
                    close_walk(udef_pkg::STATUS_MALFORMED);
                    return;
                end
            end
            if (p == 1 && o != 1 && (len < 2 || o - 1 + len > total_len)) begin
                close_walk(udef_pkg::STATUS_MALFORMED);
                return;
            end

            if (desc_type == udef_pkg::TYPE_INTERFACE && len >= udef_pkg::MIN_IFACE_LEN)
            begin
                case (p)
                    2: match_ok = (b == match_reg[udef_pkg::CFG_IFACE_NUMBER]);
                    3: match_ok = match_ok && (b == match_reg[udef_pkg::CFG_ALT_SETTING]);
                    5: match_ok = match_ok && (b == match_reg[udef_pkg::CFG_IFACE_CLASS]);
                    6: match_ok = match_ok && (b == match_reg[udef_pkg::CFG_IFACE_SUBCLASS]);
                    7:
                    begin
                        match_ok  = match_ok
                                    && (b == match_reg[udef_pkg::CFG_IFACE_PROTOCOL]);
                        in_target = match_ok;
                    end
                    default: ;
                endcase
            end
            else if (in_target && desc_type == udef_pkg::TYPE_ENDPOINT
                     && len >= udef_pkg::MIN_EP_LEN) begin
                if (p == 2)
                    addr_hold = b;
                else if (p == 3 && b[1:0] == udef_pkg::XFER_INTERRUPT) begin
                    if (addr_hold[7])
                        in_addr = addr_hold;
                    else
                        out_addr = addr_hold;
                end
            end

            n = o + 1;
            offset = n[15:0];
            if (len >= 2 && p + 1 == len) begin
                pos = '0;
                if (n >= 4 && n + 2 > total_len)
                    close_walk(udef_pkg::STATUS_OK);
            end
            else
                pos = 8'(p + 1);
        endfunction

        function void check_report(udef_pkg::result_t got);
            udef_pkg::result_t exp;
            if (expected_reports.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected report found=%0b in=%02h out=%02h status=%0d",
                             got.found, got.in_endpoint, got.out_endpoint, got.walk_status);
                return;
            end
            exp = expected_reports.pop_front();
            n_checked++;
            if (got.found !== exp.found || got.in_endpoint !== exp.in_endpoint ||
                got.out_endpoint !== exp.out_endpoint || got.walk_status !== exp.walk_status)
            begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("ERROR: report %0d expected found=%0b in=%02h out=%02h status=%0d",
                             n_checked, exp.found, exp.in_endpoint, exp.out_endpoint,
                             exp.walk_status);
                    $display("       got found=%0b in=%02h out=%02h status=%0d",
                             got.found, got.in_endpoint, got.out_endpoint, got.walk_status);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    udef_desc_if   desc_ch ();
    udef_result_if rpt_ch ();
    udef_cfg_if    cfg_ch ();

    usb_descriptor_endpoint_finder i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .desc   (desc_ch),
        .result (rpt_ch),
        .cfg    (cfg_ch)
    );

    walk_predictor book;
    logic [7:0]    set_bytes [$];
    int unsigned   desc_heads [$];
    int unsigned   bytes_sent;
    int unsigned   settings_used;
    int unsigned   cycles;
    bit            no_gaps;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        udef_pkg::result_t got;
        if (rst_n) begin
            if (rpt_ch.valid && rpt_ch.ready) begin
                got.found        = rpt_ch.found;
                got.in_endpoint  = rpt_ch.in_endpoint;
                got.out_endpoint = rpt_ch.out_endpoint;
                got.walk_status  = udef_pkg::walk_status_t'(rpt_ch.walk_status);
                book.check_report(got);
            end
            if (desc_ch.valid && desc_ch.ready)
                book.take_byte(desc_ch.desc_byte, desc_ch.first_byte);
            if (cfg_ch.valid && cfg_ch.ready)
                book.write_reg(udef_pkg::cfg_index_t'(cfg_ch.index), cfg_ch.data);
        end
    end

    // Result side back-pressure
    initial
    begin
        int unsigned stall;
        rpt_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                rpt_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rpt_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rpt_ch.valid) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            desc_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        desc_ch.valid      <= 1'b1;
        desc_ch.desc_byte  <= b;
        desc_ch.first_byte <= first;
        @(posedge clk);
        while (!desc_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_set();
        foreach (set_bytes[i])
            send_byte(set_bytes[i], i == 0);
    endtask

    // Wait until every report is in and the walk logic has gone quiet
    task automatic settle();
        desc_ch.valid <= 1'b0;
        @(posedge clk);
        while (book.expected_reports.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_match_regs(input logic [7:0] vals [0:4]);
        for (int i = 0; i <= udef_pkg::CFG_IFACE_PROTOCOL; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= udef_pkg::cfg_index_t'(i);
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic void append_descriptor(logic [7:0] d [$], int unsigned len);
        while (d.size() > len) void'(d.pop_back());
        while (d.size() < len) d.push_back(8'($urandom));
        desc_heads.push_back(set_bytes.size());
        set_bytes = {set_bytes, d};
    endfunction

    function automatic void add_interface();
        logic [7:0]  f [0:4];
        logic [7:0]  d [$];
        int unsigned kind, sel, len;
        foreach (f[i])
            f[i] = book.match_reg[i];
        kind = $urandom_range(0, 9);
        if (kind == 6 || kind == 7) begin
            sel = $urandom_range(0, 4);
            f[sel] = f[sel] ^ 8'(1 << $urandom_range(0, 7));
        end
        else if (kind == 8) begin
            foreach (f[i])
                f[i] = 8'($urandom);
        end
        if (kind == 9)
            len = $urandom_range(2, 8);
        else if ($urandom_range(0, 7) == 0)
            len = $urandom_range(10, 12);
        else
            len = udef_pkg::MIN_IFACE_LEN;
        d = {8'(len), udef_pkg::TYPE_INTERFACE, f[0], f[1], 8'($urandom_range(0, 3)),
             f[2], f[3], f[4], 8'($urandom)};
        append_descriptor(d, len);
    endfunction

    function automatic void add_endpoint();
        logic [7:0]  d [$];
        logic [7:0]  attr;
        int unsigned len;
        attr = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            attr[1:0] = udef_pkg::XFER_INTERRUPT;
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(2, 6);
            1:       len = 9;
            default: len = udef_pkg::MIN_EP_LEN;
        endcase
        d = {8'(len), udef_pkg::TYPE_ENDPOINT, 8'($urandom), attr,
             8'($urandom_range(8, 64)), 8'd0, 8'($urandom_range(1, 16))};
        append_descriptor(d, len);
    endfunction

    function automatic void build_config_set();
        logic [7:0]  d [$];
        int unsigned total, head;
        set_bytes.delete();
        desc_heads.delete();
        d = {8'd9, TYPE_CONFIG};
        append_descriptor(d, 9);
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 2) == 0) begin
                d = {8'd9, ($urandom_range(0, 1) == 0) ? TYPE_HID : 8'($urandom)};
                append_descriptor(d, 9);
            end
            add_interface();
            repeat ($urandom_range(0, 3)) add_endpoint();
        end
        total = set_bytes.size();
        case ($urandom_range(0, 9))
            0:       total = total + 1;
            1:       total = total + $urandom_range(2, 40);
            2:       total = total - $urandom_range(1, total - 9);
            default: ;
        endcase
        set_bytes[2] = total[7:0];
        set_bytes[3] = total[15:8];
        if ($urandom_range(0, 9) == 0) begin
            head = desc_heads[$urandom_range(1, desc_heads.size() - 1)];
            set_bytes[head] = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 1));
        end
    endfunction

    task automatic run_random_sets(input int unsigned byte_goal);
        int unsigned start, shape;
        start = bytes_sent;
        while (bytes_sent - start < byte_goal) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            shape = $urandom_range(0, 99);
            if (shape < 70)
                build_config_set();
            else if (shape < 82) begin
                // abandoned part-way, the next set restarts the walk
                build_config_set();
                set_bytes = set_bytes[0:$urandom_range(1, set_bytes.size() - 2)];
            end
            else if (shape < 90)
                set_bytes = {8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)), 8'd0};
            else begin
                set_bytes.delete();
                repeat ($urandom_range(1, 16)) set_bytes.push_back(8'($urandom));
            end
            send_set();
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    initial
    begin
        logic [7:0] vals [0:4];
        clk                = 1'b0;
        rst_n              = 1'b0;
        cycles             = 0;
        bytes_sent         = 0;
        settings_used      = 1;
        no_gaps            = 1'b0;
        desc_ch.valid      = 1'b0;
        desc_ch.desc_byte  = '0;
        desc_ch.first_byte = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = udef_pkg::CFG_IFACE_NUMBER;
        cfg_ch.data        = '0;
        book = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under the reset match values
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        set_bytes = {8'd9, TYPE_CONFIG, 8'd8, 8'd0};
        send_set();
        set_bytes = {8'hFF, 8'h00, 8'h00, 8'h00};
        send_set();
        set_bytes = {8'd1, TYPE_CONFIG, 8'd9, 8'd0};
        send_set();
        set_bytes = {8'h20, TYPE_CONFIG, 8'd9, 8'd0};
        send_set();
        set_bytes = {8'd9, TYPE_CONFIG, 8'd12, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
                     8'd5, udef_pkg::TYPE_INTERFACE};
        send_set();
        set_bytes = {8'd9, TYPE_CONFIG, 8'h20, 8'h00, 8'd1};
        send_set();
        set_bytes = {8'd9, TYPE_CONFIG, 8'h20, 8'h00, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
                     8'd9, udef_pkg::TYPE_INTERFACE, udef_pkg::IFACE_NUMBER_RST,
                     udef_pkg::ALT_SETTING_RST, 8'd2, udef_pkg::IFACE_CLASS_RST,
                     udef_pkg::IFACE_SUBCLASS_RST, udef_pkg::IFACE_PROTOCOL_RST, 8'd0,
                     8'd7, udef_pkg::TYPE_ENDPOINT, 8'h81, 8'h03, 8'd32, 8'd0, 8'd4,
                     8'd7, udef_pkg::TYPE_ENDPOINT, 8'h01, 8'h03, 8'd32, 8'd0, 8'd8};
        send_set();
        set_bytes = {8'd9, TYPE_CONFIG, 8'd9, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50};
        send_set();
        set_bytes = {8'd9, TYPE_CONFIG, 8'hFF, 8'hFF, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
                     8'd0, 8'hFF};
        send_set();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            foreach (vals[i])
                vals[i] = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom);
            load_match_regs(vals);
            run_random_sets(BYTES_PER_PHASE);
        end

        settle();
        repeat (16) @(posedge clk);
        $display("Sent %0d descriptor bytes under %0d match-register settings,",
                 bytes_sent, settings_used);
        $display("checked %0d walk reports, %0d mismatches.", book.n_checked, book.n_errors);
        if (book.n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
